// ===== src/action_potential_duration_meter_core_assert.svh =====
// Assertion macros for the action potential duration meter core.
// The asserting module provides clk and rst_n.
`ifndef ACTION_POTENTIAL_DURATION_METER_CORE_ASSERT_SVH
`define ACTION_POTENTIAL_DURATION_METER_CORE_ASSERT_SVH

// Same-cycle implication.
`define APD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/apd_pkg.sv =====
// ----------------------------------------------------------------------------
// apd_pkg
// Shared widths, register indexes, event codes and reset values for the
// action potential duration meter.
// ----------------------------------------------------------------------------
package apd_pkg;

  localparam int NODE_COUNT_DEF = 1024;

  localparam int NODE_W     = 10;
  localparam int POT_W      = 16;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int CHG_W      = 33;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 1'b1;

  // event codes
  localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_ACT   = 2'd1;
  localparam logic [KIND_W-1:0] EV_REPOL = 2'd2;

  localparam logic signed [POT_W-1:0] THRESHOLD_RST = 16'sd2560;
  localparam logic [POT_W-1:0]        STEP_RST      = 16'd102;

endpackage

// ===== src/apd_in_if.sv =====
// ----------------------------------------------------------------------------
// apd_in_if
// Sample request channel: node, potential and sample time.
// ----------------------------------------------------------------------------
interface apd_in_if;
  import apd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NODE_W-1:0]       node_index;
  logic signed [POT_W-1:0] potential_sample;
  logic [TIME_W-1:0]       sample_time;

  modport source (output valid, output node_index, output potential_sample,
                  output sample_time, input ready);
  modport sink   (input valid, input node_index, input potential_sample,
                  input sample_time, output ready);
endinterface

// ===== src/apd_out_if.sv =====
// ----------------------------------------------------------------------------
// apd_out_if
// Result channel: node, event kind, crossing time, duration and its change.
// ----------------------------------------------------------------------------
interface apd_out_if;
  import apd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NODE_W-1:0]       node_out;
  logic [KIND_W-1:0]       event_kind;
  logic [TIME_W-1:0]       crossing_time;
  logic [TIME_W-1:0]       pulse_duration;
  logic signed [CHG_W-1:0] duration_change;

  modport source (output valid, output node_out, output event_kind,
                  output crossing_time, output pulse_duration,
                  output duration_change, input ready);
  modport sink   (input valid, input node_out, input event_kind,
                  input crossing_time, input pulse_duration,
                  input duration_change, output ready);
endinterface

// ===== src/apd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// apd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface apd_cfg_if;
  import apd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/action_potential_duration_meter_core.sv =====
// ----------------------------------------------------------------------------
// action_potential_duration_meter_core
// Takes one request at a time: a new request is accepted only once the
//   result of the last has moved into the output register. A request for
//   a node beyond the store goes straight to an empty result. Compares and
//   differences run on the single shared subtractor, which also runs the 16-step divide.
// Reset: clears control state, then a clearing pass zeroes the per-node
//   stores; no request is taken until it ends.
// ----------------------------------------------------------------------------
`include "action_potential_duration_meter_core_assert.svh"

module action_potential_duration_meter_core #(
  parameter int NODE_COUNT = apd_pkg::NODE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  apd_in_if.sink    in_req,
  apd_out_if.source out_res,
  apd_cfg_if.sink   cfg_wr
);
  import apd_pkg::*;

  localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int QUO_W = POT_W;            // offset never exceeds step_interval
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
  localparam logic [AW-1:0]    CLR_LAST = AW'(NODE_COUNT - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CMP_CUR  = 4'd2;
  localparam logic [3:0] S_CMP_PREV = 4'd3;
  localparam logic [3:0] S_NUM      = 4'd4;
  localparam logic [3:0] S_DEN      = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_TIME     = 4'd8;
  localparam logic [3:0] S_DUR      = 4'd9;
  localparam logic [3:0] S_CHG      = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [3:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;
  logic signed [POT_W-1:0] thr_r;
  logic [POT_W-1:0]        step_r;

  // request held for the duration of the work
  logic [NODE_W-1:0]       node_r, node_nxt;
  logic signed [POT_W-1:0] cur_r, cur_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;

  // working values
  logic                    cur_neg_r, cur_neg_nxt;   // current below threshold
  logic                    up_r, up_nxt;             // upward crossing
  logic [POT_W-1:0]        num_r, num_nxt;
  logic [POT_W-1:0]        den_r, den_nxt;
  logic [TIME_W-1:0]       rq_r, rq_nxt;             // remainder | dividend/quotient
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [TIME_W-1:0]       t_r, t_nxt;
  logic [TIME_W-1:0]       d_r, d_nxt;

  // pending result
  logic [KIND_W-1:0]       res_kind_r, res_kind_nxt;
  logic [TIME_W-1:0]       res_time_r, res_time_nxt;
  logic [TIME_W-1:0]       res_dur_r, res_dur_nxt;
  logic [CHG_W-1:0]        res_chg_r, res_chg_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]       out_node_r, out_node_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [TIME_W-1:0]       out_time_r, out_time_nxt;
  logic [TIME_W-1:0]       out_dur_r, out_dur_nxt;
  logic [CHG_W-1:0]        out_chg_r, out_chg_nxt;

  // per-node stores, registered read
  logic [POT_W-1:0]  pot_mem [NODE_COUNT];
  logic [TIME_W-1:0] act_mem [NODE_COUNT];
  logic [TIME_W-1:0] dur_mem [NODE_COUNT];
  logic [POT_W-1:0]  prev_rd_r;
  logic [TIME_W-1:0] act_rd_r;
  logic [TIME_W-1:0] last_rd_r;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic              acc;
  logic              out_fire;
  logic              in_range;
  logic [31:0]       node_ext;
  logic [AW-1:0]     acc_addr;

  assign in_req.ready = (state_r == S_IDLE);
  assign acc          = in_req.valid && in_req.ready;
  assign out_fire     = out_res.valid && out_res.ready;
  assign node_ext     = 32'(in_req.node_index);
  assign acc_addr     = node_ext[AW-1:0];
  assign in_range     = node_ext < 32'(NODE_COUNT);

  assign cfg_wr.ready = 1'b1;

  // --------------------------------------------------------------------------
  // Shared subtractor: all threshold compares, differences and divider steps.
  // 33-bit operands, extended by one bit so bit 33 is the sign / borrow.
  // --------------------------------------------------------------------------
  logic [32:0] sub_a, sub_b;
  logic [33:0] sub_res;
  logic [32:0] cur_sx, thr_sx, prev_sx;

  assign cur_sx  = {{17{cur_r[POT_W-1]}}, cur_r};
  assign thr_sx  = {{17{thr_r[POT_W-1]}}, thr_r};
  assign prev_sx = {{17{prev_rd_r[POT_W-1]}}, prev_rd_r};

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      S_CMP_CUR: begin
        sub_a = cur_sx;
        sub_b = thr_sx;
      end
      S_CMP_PREV: begin
        sub_a = prev_sx;
        sub_b = thr_sx;
      end
      S_NUM: begin
        sub_a = up_r ? cur_sx : thr_sx;
        sub_b = up_r ? thr_sx : cur_sx;
      end
      S_DEN: begin
        sub_a = up_r ? cur_sx : prev_sx;
        sub_b = up_r ? prev_sx : cur_sx;
      end
      S_DIV: begin
        // partial remainder with the next dividend bit shifted in
        sub_a = {16'd0, rq_r[31:15]};
        sub_b = {17'd0, den_r};
      end
      S_TIME: begin
        sub_a = {1'b0, now_r};
        sub_b = {17'd0, rq_r[QUO_W-1:0]};
      end
      S_DUR: begin
        sub_a = {1'b0, t_r};
        sub_b = {1'b0, act_rd_r};
      end
      S_CHG: begin
        sub_a = {1'b0, d_r};
        sub_b = {1'b0, last_rd_r};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_res = {sub_a[32], sub_a} - {sub_b[32], sub_b};

  // one 16 x 16 multiply: |c - h| * step_interval
  logic [TIME_W-1:0] prod;
  assign prod = {16'd0, num_r} * {16'd0, step_r};

  // --------------------------------------------------------------------------
  // Store write port
  // --------------------------------------------------------------------------
  logic              pot_we, act_we, dur_we;
  logic [AW-1:0]     wr_addr;
  logic [POT_W-1:0]  pot_wd;
  logic [TIME_W-1:0] act_wd, dur_wd;

  always_ff @(posedge clk) begin
    if (pot_we) begin
      pot_mem[wr_addr] <= pot_wd;
    end
    if (acc) begin
      prev_rd_r <= pot_mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[wr_addr] <= act_wd;
    end
    if (acc) begin
      act_rd_r <= act_mem[acc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (dur_we) begin
      dur_mem[wr_addr] <= dur_wd;
    end
    if (acc) begin
      last_rd_r <= dur_mem[acc_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic div_ok;
  logic prev_neg;
  logic up_x, down_x;

  assign div_ok   = !sub_res[33];
  assign prev_neg = sub_res[33];
  assign up_x     = prev_neg && !cur_neg_r;
  assign down_x   = !prev_neg && cur_neg_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    now_nxt       = now_r;
    addr_nxt      = addr_r;
    cur_neg_nxt   = cur_neg_r;
    up_nxt        = up_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rq_nxt        = rq_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    d_nxt         = d_r;
    res_kind_nxt  = res_kind_r;
    res_time_nxt  = res_time_r;
    res_dur_nxt   = res_dur_r;
    res_chg_nxt   = res_chg_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_node_nxt  = out_node_r;
    out_kind_nxt  = out_kind_r;
    out_time_nxt  = out_time_r;
    out_dur_nxt   = out_dur_r;
    out_chg_nxt   = out_chg_r;

    pot_we  = 1'b0;
    act_we  = 1'b0;
    dur_we  = 1'b0;
    wr_addr = addr_r;
    pot_wd  = cur_r;
    act_wd  = res_time_r;
    dur_wd  = d_r;

    case (state_r)
      S_CLEAR: begin
        // one entry of each store per cycle
        pot_we  = 1'b1;
        act_we  = 1'b1;
        dur_we  = 1'b1;
        wr_addr = clr_r;
        pot_wd  = '0;
        act_wd  = '0;
        dur_wd  = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (acc) begin
          node_nxt     = in_req.node_index;
          cur_nxt      = in_req.potential_sample;
          now_nxt      = in_req.sample_time;
          addr_nxt     = acc_addr;
          res_kind_nxt = EV_NONE;
          res_time_nxt = '0;
          res_dur_nxt  = '0;
          res_chg_nxt  = '0;
          // node beyond the store: empty result, no state touched
          state_nxt    = in_range ? S_CMP_CUR : S_OUT;
        end
      end

      S_CMP_CUR: begin
        cur_neg_nxt = sub_res[33];
        state_nxt   = S_CMP_PREV;
      end

      S_CMP_PREV: begin
        up_nxt = up_x;
        if (up_x || down_x) begin
          state_nxt = S_NUM;
        end else begin
          pot_we    = 1'b1;
          state_nxt = S_OUT;
        end
      end

      S_NUM: begin
        num_nxt   = sub_res[POT_W-1:0];
        state_nxt = S_DEN;
      end

      S_DEN: begin
        den_nxt   = sub_res[POT_W-1:0];
        state_nxt = S_MUL;
      end

      S_MUL: begin
        rq_nxt    = prod;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        // restoring step; top half stays below the divisor
        rq_nxt  = {(div_ok ? sub_res[15:0] : rq_r[30:15]), rq_r[14:0], div_ok};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_TIME;
        end
      end

      S_TIME: begin
        // crossing before time zero saturates
        t_nxt        = sub_res[33] ? '0 : sub_res[TIME_W-1:0];
        res_time_nxt = t_nxt;
        if (up_r) begin
          res_kind_nxt = EV_ACT;
          pot_we       = 1'b1;
          act_we       = 1'b1;
          act_wd       = t_nxt;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_DUR;
        end
      end

      S_DUR: begin
        // negative duration saturates
        d_nxt       = sub_res[33] ? '0 : sub_res[TIME_W-1:0];
        res_dur_nxt = d_nxt;
        state_nxt   = S_CHG;
      end

      S_CHG: begin
        res_chg_nxt  = sub_res[CHG_W-1:0];
        res_kind_nxt = EV_REPOL;
        pot_we       = 1'b1;
        dur_we       = 1'b1;
        state_nxt    = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = node_r;
          out_kind_nxt  = res_kind_r;
          out_time_nxt  = res_time_r;
          out_dur_nxt   = res_dur_r;
          out_chg_nxt   = res_chg_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    cur_r      <= cur_nxt;
    now_r      <= now_nxt;
    addr_r     <= addr_nxt;
    cur_neg_r  <= cur_neg_nxt;
    up_r       <= up_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rq_r       <= rq_nxt;
    cnt_r      <= cnt_nxt;
    t_r        <= t_nxt;
    d_r        <= d_nxt;
    res_kind_r <= res_kind_nxt;
    res_time_r <= res_time_nxt;
    res_dur_r  <= res_dur_nxt;
    res_chg_r  <= res_chg_nxt;
    out_node_r <= out_node_nxt;
    out_kind_r <= out_kind_nxt;
    out_time_r <= out_time_nxt;
    out_dur_r  <= out_dur_nxt;
    out_chg_r  <= out_chg_nxt;
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      step_r <= STEP_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        REG_THRESHOLD: thr_r  <= $signed(cfg_wr.data);
        REG_STEP:      step_r <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_res.valid           = out_valid_r;
  assign out_res.node_out        = out_node_r;
  assign out_res.event_kind      = out_kind_r;
  assign out_res.crossing_time   = out_time_r;
  assign out_res.pulse_duration  = out_dur_r;
  assign out_res.duration_change = $signed(out_chg_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic chk_none, chk_act, chk_empty, chk_no_dur, chk_div_mid, chk_clear_ok;

  assign chk_none     = out_res.valid && out_res.event_kind == EV_NONE;
  assign chk_act      = out_res.valid && out_res.event_kind == EV_ACT;
  assign chk_no_dur   = out_res.pulse_duration == '0 && out_res.duration_change == '0;
  assign chk_empty    = out_res.crossing_time == '0 && chk_no_dur;
  assign chk_div_mid  = state_r == S_DIV && cnt_r != DIV_LAST;
  assign chk_clear_ok = !in_req.ready && !out_valid_r;

  `APD_ASSERT_NOW(a_none_is_empty, chk_none, chk_empty, "empty result carries data")
  `APD_ASSERT_NOW(a_act_no_duration, chk_act, chk_no_dur, "activation carries a duration")
  `APD_ASSERT_NEXT(a_div_runs, chk_div_mid, state_r == S_DIV, "divider left early")
  `APD_ASSERT_NOW(a_clear_blocks, state_r == S_CLEAR, chk_clear_ok, "request while clearing")

endmodule

// ===== sim/apd_event_checker.sv =====
// ----------------------------------------------------------------------------
// apd_event_checker
// Watches the sample, result and configuration channels of the action
// potential duration meter, predicts the result of every accepted request
// and compares it with what the core returns, oldest first.
// ----------------------------------------------------------------------------
module apd_event_checker #(
  parameter int NODE_COUNT = apd_pkg::NODE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  apd_in_if    in_mon,
  apd_out_if   out_mon,
  apd_cfg_if   cfg_mon,
  output int   fail_count,
  output int   outstanding
);
  import apd_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic [KIND_W-1:0]       kind;
    logic [TIME_W-1:0]       ctime;
    logic [TIME_W-1:0]       dur;
    logic signed [CHG_W-1:0] dchg;
  } apd_event_t;

  apd_event_t expected_events[$];

  // per-node history
  logic signed [POT_W-1:0] node_potential  [NODE_COUNT];
  logic [TIME_W-1:0]       node_activation [NODE_COUNT];
  logic [TIME_W-1:0]       node_duration   [NODE_COUNT];

  logic signed [POT_W-1:0] threshold;
  logic [CFG_DATA_W-1:0]   step_ticks;
  int                      reports;

  // Linear interpolation back from the new sample to the threshold.
  function automatic logic [TIME_W-1:0] interpolate_crossing(
    input logic [TIME_W-1:0]       now,
    input logic signed [POT_W-1:0] cur,
    input logic signed [POT_W-1:0] prev
  );
    longint rise;
    longint span;
    longint shift;
    rise = longint'(cur) - longint'(threshold);
    if (rise < 0) rise = -rise;
    span = longint'(cur) - longint'(prev);
    if (span < 0) span = -span;
    if (span == 0) return now;
    shift = rise * longint'(step_ticks) / span;
    if (shift > longint'(now)) return '0;  // crossing before time zero
    return now - shift[TIME_W-1:0];
  endfunction

  function automatic apd_event_t predict_event(
    input logic [NODE_W-1:0]       node,
    input logic signed [POT_W-1:0] cur,
    input logic [TIME_W-1:0]       now
  );
    apd_event_t              ev;
    logic signed [POT_W-1:0] prev;
    logic [TIME_W-1:0]       t;
    logic [TIME_W-1:0]       d;
    longint                  delta;
    ev      = '0;
    ev.node = node;
    if (int'(node) < NODE_COUNT) begin
      prev = node_potential[node];
      if (prev < threshold && cur >= threshold) begin
        t = interpolate_crossing(now, cur, prev);
        node_activation[node] = t;
        ev.kind  = EV_ACT;
        ev.ctime = t;
      end else if (prev >= threshold && cur < threshold) begin
        t = interpolate_crossing(now, cur, prev);
        d = (t >= node_activation[node]) ? t - node_activation[node] : '0;
        delta = longint'(d) - longint'(node_duration[node]);
        node_duration[node] = d;
        ev.kind  = EV_REPOL;
        ev.ctime = t;
        ev.dur   = d;
        ev.dchg  = delta[CHG_W-1:0];
      end
      node_potential[node] = cur;
    end
    return ev;
  endfunction

  always @(posedge clk) begin
    apd_event_t got;
    apd_event_t want;
    apd_event_t pred;
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_potential[i]  = '0;
        node_activation[i] = '0;
        node_duration[i]   = '0;
      end
      threshold  = THRESHOLD_RST;
      step_ticks = STEP_RST;
      expected_events.delete();
      fail_count = 0;
      reports    = 0;
    end else begin
      // results first: a result never belongs to a request taken at this edge
      if (out_mon.valid && out_mon.ready) begin
        got.node  = out_mon.node_out;
        got.kind  = out_mon.event_kind;
        got.ctime = out_mon.crossing_time;
        got.dur   = out_mon.pulse_duration;
        got.dchg  = out_mon.duration_change;
        if (expected_events.size() == 0) begin
          fail_count++;
          if (reports < 10)
            $display("unexpected result for node %0d, nothing pending", got.node);
          reports++;
        end else begin
          want = expected_events.pop_front();
          if (got.node !== want.node || got.kind !== want.kind ||
              got.ctime !== want.ctime || got.dur !== want.dur ||
              got.dchg !== want.dchg) begin
            fail_count++;
            if (reports < 10) begin
              $display("mismatch: expected node %0d kind %0d time %0d dur %0d chg %0d",
                       want.node, want.kind, want.ctime, want.dur, $signed(want.dchg));
              $display("          got      node %0d kind %0d time %0d dur %0d chg %0d",
                       got.node, got.kind, got.ctime, got.dur, $signed(got.dchg));
            end
            reports++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_THRESHOLD)
          threshold = cfg_mon.data;
        else if (cfg_mon.index == REG_STEP)
          step_ticks = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        pred = predict_event(in_mon.node_index, in_mon.potential_sample,
                             in_mon.sample_time);
        expected_events = {expected_events, pred};
      end
    end
    outstanding = expected_events.size();
  end

endmodule

// ===== sim/tb_action_potential_duration_meter_core.sv =====
// ----------------------------------------------------------------------------
// tb_action_potential_duration_meter_core
// Drives sample requests and register writes into the duration meter core
// and leaves prediction and comparison to apd_event_checker. A directed
// opening covers the corner cases, then six random phases run action
// potential shaped traces over a small node pool, with noise, under
// varying thresholds, step intervals and handshake pressure.
// ----------------------------------------------------------------------------
module tb_action_potential_duration_meter_core;
  import apd_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int PHASE_COUNT      = 6;
  localparam int HOLD_CYCLES      = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES     = 40;    // margin beyond the longest (repolarisation) latency
  localparam int POOL_SIZE        = 8;

  logic clk;
  logic rst_n;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // handshake pressure, percent of cycles
  int send_idle_pct;
  int stall_pct;
  bit hold_wanted;
  bit hold_done;
  int hold_count;

  // our view of the register settings, for shaping traces
  logic signed [POT_W-1:0] thr_now;
  logic [CFG_DATA_W-1:0]   step_now;

  // per-node sample clocks and the pool of nodes carrying traces
  logic [TIME_W-1:0] node_clock [NODE_COUNT_DEF];
  logic [NODE_W-1:0] pool_node  [POOL_SIZE];
  bit                pool_above [POOL_SIZE];
  int                pool_left  [POOL_SIZE];

  apd_in_if  in_ch ();
  apd_out_if out_ch ();
  apd_cfg_if cfg_ch ();

  action_potential_duration_meter_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch),
    .cfg_wr  (cfg_ch)
  );

  apd_event_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off counted here so the
  // core backs up and has to refuse requests.
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    hold_count   = 0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        out_ch.ready = 1'b0;
        hold_count++;
        if (hold_count == HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one sample request, idling first at random. Entered and left just
  // after a falling edge; valid stays high when requests follow back to back.
  task automatic send_sample(input logic [NODE_W-1:0] node,
                             input logic signed [POT_W-1:0] pot,
                             input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid            = 1'b1;
    in_ch.node_index       = node;
    in_ch.potential_sample = pot;
    in_ch.sample_time      = stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes only go in once every result is back; every request
  // yields a result, so an empty scoreboard means the core is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_THRESHOLD)
      thr_now = value;
    else
      step_now = value;
  endtask

  // One random request: mostly a pool node walking through rest, upstroke,
  // plateau and repolarisation around the current threshold; some noise.
  task automatic send_random_item();
    int                      slot;
    int                      spread;
    int                      level;
    int                      pick;
    logic [NODE_W-1:0]       node;
    logic signed [POT_W-1:0] pot;
    if ($urandom_range(99) < 15) begin
      // noise: any node, any potential, any time
      node = NODE_W'($urandom_range(NODE_COUNT_DEF - 1));
      pot  = POT_W'($urandom);
      send_sample(node, pot, $urandom);
      return;
    end
    slot = $urandom_range(POOL_SIZE - 1);
    node = pool_node[slot];
    if (pool_left[slot] == 0) begin
      pool_above[slot] = !pool_above[slot];
      pool_left[slot]  = $urandom_range(4, 1);
    end
    pool_left[slot]--;
    case ($urandom_range(3))
      0:       spread = 0;
      1:       spread = 255;
      2:       spread = 4000;
      default: spread = 65535;
    endcase
    if (pool_above[slot])
      level = int'(thr_now) + int'($urandom_range(spread));
    else
      level = int'(thr_now) - 1 - int'($urandom_range(spread));
    if (level > 32767) level = 32767;
    if (level < -32768) level = -32768;
    pot = level[POT_W-1:0];
    // sample clock: mostly one step on, sometimes near zero (crossing
    // before time zero), a jump, or a step back (negative duration)
    pick = $urandom_range(99);
    if (pick < 4)
      node_clock[node] = $urandom_range(200);
    else if (pick < 8)
      node_clock[node] = $urandom;
    else if (pick < 11)
      node_clock[node] = node_clock[node] - $urandom_range(5000);
    else
      node_clock[node] = node_clock[node] + step_now;
    send_sample(node, pot, node_clock[node]);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] thr_set;
    logic [CFG_DATA_W-1:0] step_set;

    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.node_index       = '0;
    in_ch.potential_sample = '0;
    in_ch.sample_time      = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_THRESHOLD;
    cfg_ch.data            = '0;
    send_idle_pct          = 0;
    stall_pct              = 0;
    hold_wanted            = 1'b0;
    thr_now                = THRESHOLD_RST;
    step_now               = STEP_RST;
    for (int i = 0; i < NODE_COUNT_DEF; i++) node_clock[i] = '0;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // --- directed opening, reset settings ---
    send_sample(10'd0,    16'sd0,      32'd1000);  // first sample, no crossing
    send_sample(10'd0,    16'sd5000,   32'd1102);  // activation
    send_sample(10'd0,    16'sd100,    32'd1204);  // repolarisation
    send_sample(10'd1,    16'sd32767,  32'd10);    // activation before time zero
    send_sample(10'd1,    16'sh8000,   32'd5);     // repol before time zero
    send_sample(10'd2,    16'sd3000,   32'd5000);  // activation late ...
    send_sample(10'd2,    16'sd0,      32'd3000);  // ... repol earlier: negative
    send_sample(10'd1023, 16'sd32767,  32'hFFFF_FFFF);
    send_sample(10'd1023, 16'sh8000,   32'hFFFF_FFFF);
    send_sample(10'd0,    16'sd2560,   32'd2000);  // exactly on threshold
    send_sample(10'd0,    16'sd2559,   32'd2102);  // just below: zero duration
    // zero step interval: crossing lands on the sample time
    write_reg(REG_STEP, 16'd0);
    send_sample(10'd3,    16'sd4000,   32'd7);
    send_sample(10'd3,    -16'sd4000,  32'd9);
    // lowest threshold: nothing can lie below it
    write_reg(REG_THRESHOLD, 16'h8000);
    write_reg(REG_STEP, 16'hFFFF);
    send_sample(10'd4,    16'sh8000,   32'd100);
    send_sample(10'd4,    16'sd32767,  32'd200);
    // highest threshold: only full scale crosses
    write_reg(REG_THRESHOLD, 16'h7FFF);
    send_sample(10'd5,    16'sd32767,  32'd70000);
    send_sample(10'd5,    16'sh8000,   32'd140000);
    send_sample(10'd5,    16'sd32766,  32'd210000);

    // --- random phases ---
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       begin thr_set = THRESHOLD_RST; step_set = STEP_RST; end
        1:       begin thr_set = 16'hFF00;      step_set = 16'hFFFF; end
        2:       begin thr_set = 16'h7FFF;      step_set = 16'd1;    end
        3:       begin thr_set = 16'h8001;      step_set = 16'd500;  end
        4:       begin
          thr_set  = CFG_DATA_W'($urandom);
          step_set = CFG_DATA_W'($urandom_range(65535, 1));
        end
        default: begin thr_set = 16'd0;         step_set = 16'd1024; end
      endcase
      write_reg(REG_THRESHOLD, thr_set);
      write_reg(REG_STEP, step_set);

      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 58; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      // back-to-back requests against a held result port
      if (ph == 0) hold_wanted = 1'b1;

      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_node[i]  = NODE_W'($urandom_range(NODE_COUNT_DEF - 1));
        pool_above[i] = 1'b0;
        pool_left[i]  = 0;
      end
      repeat (RANDOM_PER_PHASE) send_random_item();
    end

    // --- drain ---
    in_ch.valid   = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
